// File: rtl/core/ula_sync_nmi_timing_defines.svh
// Assertion macros used by the video timing RTL.
// Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef ULA_SYNC_NMI_TIMING_DEFINES_SVH
`define ULA_SYNC_NMI_TIMING_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset
`define USNT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset
`define USNT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/usnt_pkg.sv
`default_nettype none

package usnt_pkg;

  // Line timing, in clock states
  localparam logic signed [8:0] LineLen  = 9'sd207;
  localparam logic signed [8:0] HsStart  = 9'sd16;
  localparam logic signed [8:0] HsEnd    = 9'sd32;
  localparam logic signed [8:0] HoldLate = 9'sd178;
  localparam logic signed [8:0] AckPhase = -9'sd2;

  // States advanced per iteration of the phase adder
  localparam logic [3:0] Chunk = 4'd8;

  // NMI wait states: fixed count, and the base of the short-step formula
  localparam logic [4:0]        NmiWait   = 5'd14;
  localparam logic signed [9:0] WaitBase  = 10'(NmiWait + 3 + HsStart);
  localparam logic [4:0]        WaitMax   = 5'd31;
  localparam logic [5:0]        ShortStep = 6'd4;

  // Port event codes
  localparam logic [2:0] EvNone     = 3'd0;
  localparam logic [2:0] EvInEven   = 3'd1;
  localparam logic [2:0] EvOutFd    = 3'd2;
  localparam logic [2:0] EvOutFe    = 3'd3;
  localparam logic [2:0] EvOutOther = 3'd4;

  // Horizontal sync stages
  localparam logic [1:0] HsIdle   = 2'd0;
  localparam logic [1:0] HsArmed  = 2'd1;
  localparam logic [1:0] HsInSync = 2'd2;

  // Vertical sync modes
  localparam logic [1:0] VsOff     = 2'd0;
  localparam logic [1:0] VsOn      = 2'd1;
  localparam logic [1:0] VsEndNext = 2'd2;

  // Configuration register indexes
  localparam logic RegEarlyMode   = 1'b0;
  localparam logic RegFrameLength = 1'b1;

  // Reset value of the frame length register
  localparam logic [16:0] FrameLenReset = 17'd65000;

  typedef struct packed {
    logic [5:0] step_states;
    logic [2:0] io_event;
    logic       int_ack;
  } step_t;

  typedef struct packed {
    logic       nmi_request;
    logic [4:0] wait_states;
    logic [2:0] row_count;
    logic       sync_level;
    logic       vsync_active;
    logic       frame_tick;
  } timing_t;

endpackage

`default_nettype wire

// File: rtl/core/ula_sync_nmi_timing.sv
// A step is taken in StIdle, then the phase adder iterates in StChunk, one iteration per
// chunk of up to 8 states over the step states plus any wait states, at least 1 and at most 10,
// and StFrame delivers the result once the output register is free.
// No new step is taken until the current one is back in StIdle; the shared adder sets this.
// One result may wait in the output register while the next step is taken.
// Reset (rst_ni low, asynchronous) clears all timing state and reloads registers.
`default_nettype none

module ula_sync_nmi_timing (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Step channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire usnt_pkg::step_t   in_data_i,
  // Result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output usnt_pkg::timing_t      out_data_o,
  // Configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StChunk = 2'd1;
  localparam logic [1:0] StFrame = 2'd2;

  // Sequencer
  logic [1:0] state_q, state_d;

  // Configuration
  logic        early_q;
  logic [16:0] flen_q;

  // Timing state
  logic signed [8:0] phase_q, phase_d;
  logic [1:0]        stage_q, stage_d;
  logic              nmi_en_q, nmi_en_d;
  logic [1:0]        vmode_q, vmode_d;
  logic              hsync_q, hsync_d;
  logic [2:0]        row_q, row_d;
  logic              hold_q, hold_d;
  logic [16:0]       total_q, total_d;

  // Per-step working registers
  logic [6:0] rem_q, rem_d;
  logic [6:0] ts_q, ts_d;
  logic       short_q, short_d;
  logic       nreq_q, nreq_d;
  logic [4:0] wait_q, wait_d;
  logic       sync_q, sync_d;

  // Output register
  logic                 out_valid_q, out_valid_d;
  usnt_pkg::timing_t    out_q, out_d;

  logic cfg_wr;

  // Configuration writes and reads
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      early_q <= 1'b0;
      flen_q  <= usnt_pkg::FrameLenReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        usnt_pkg::RegEarlyMode:   early_q <= pwdata[0];
        usnt_pkg::RegFrameLength: flen_q  <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        usnt_pkg::RegEarlyMode:   prdata = {31'd0, early_q};
        usnt_pkg::RegFrameLength: prdata = {15'd0, flen_q};
        default:                  prdata = '0;
      endcase
    end
  end

  // Handshakes
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer and shared phase adder
  always_comb begin
    logic [2:0]        ev;
    logic              port_out;
    logic [3:0]        inc;
    logic [6:0]        rem_n;
    logic signed [9:0] wv;
    logic [4:0]        w;
    logic [17:0]       sum;
    logic              tick;

    state_d     = state_q;
    phase_d     = phase_q;
    stage_d     = stage_q;
    nmi_en_d    = nmi_en_q;
    vmode_d     = vmode_q;
    hsync_d     = hsync_q;
    row_d       = row_q;
    hold_d      = hold_q;
    total_d     = total_q;
    rem_d       = rem_q;
    ts_d        = ts_q;
    short_d     = short_q;
    nreq_d      = nreq_q;
    wait_d      = wait_q;
    sync_d      = sync_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;

    ev       = usnt_pkg::EvNone;
    port_out = 1'b0;
    inc      = '0;
    rem_n    = '0;
    wv       = '0;
    w        = '0;
    sum      = '0;
    tick     = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          // Apply interrupt acknowledge, then the port event
          if (in_data_i.int_ack) begin
            phase_d = usnt_pkg::AckPhase;
            stage_d = usnt_pkg::HsArmed;
          end
          ev = in_data_i.io_event;
          if (early_q && (ev == usnt_pkg::EvOutFd || ev == usnt_pkg::EvOutFe)) begin
            ev = usnt_pkg::EvOutOther;
          end
          unique case (ev)
            usnt_pkg::EvInEven: begin
              if (!nmi_en_q && vmode_q == usnt_pkg::VsOff) begin
                vmode_d = usnt_pkg::VsOn;
              end
            end
            usnt_pkg::EvOutFd: begin
              nmi_en_d = 1'b0;
              port_out = 1'b1;
            end
            usnt_pkg::EvOutFe: begin
              nmi_en_d = 1'b1;
              port_out = 1'b1;
            end
            usnt_pkg::EvOutOther: begin
              port_out = 1'b1;
              if (early_q) begin
                stage_d = usnt_pkg::HsArmed;
              end
            end
            default: ;
          endcase
          // Any output ends vertical sync, in early mode once horizontal sync ends
          if (port_out && vmode_q != usnt_pkg::VsOff) begin
            if (early_q) begin
              vmode_d = usnt_pkg::VsEndNext;
            end else begin
              vmode_d = usnt_pkg::VsOff;
              if (phase_d < usnt_pkg::HsStart || phase_d >= usnt_pkg::HoldLate) begin
                hold_d = 1'b1;
              end
            end
          end
          rem_d   = {1'b0, in_data_i.step_states};
          ts_d    = {1'b0, in_data_i.step_states};
          short_d = (in_data_i.step_states == usnt_pkg::ShortStep);
          nreq_d  = 1'b0;
          wait_d  = '0;
          state_d = StChunk;
        end
      end

      StChunk: begin
        // Advance the line phase by one chunk
        inc     = (rem_q > 7'(usnt_pkg::Chunk)) ? usnt_pkg::Chunk : rem_q[3:0];
        rem_n   = rem_q - 7'(inc);
        phase_d = phase_q + $signed({5'd0, inc});
        if (phase_d >= usnt_pkg::LineLen) begin
          phase_d = phase_d - usnt_pkg::LineLen;
          if (!early_q) begin
            stage_d = usnt_pkg::HsArmed;
          end
        end
        // Start horizontal sync, raising NMI when enabled
        if (stage_d == usnt_pkg::HsArmed && phase_d >= usnt_pkg::HsStart) begin
          if (nmi_en_q) begin
            wv = usnt_pkg::WaitBase - $signed({3'd0, rem_n}) - $signed({phase_d[8], phase_d});
            if (!short_q) begin
              w = usnt_pkg::NmiWait;
            end else if (wv < 10'sd0) begin
              w = '0;
            end else if (wv > $signed({5'd0, usnt_pkg::WaitMax})) begin
              w = usnt_pkg::WaitMax;
            end else begin
              w = wv[4:0];
            end
            nreq_d = 1'b1;
            wait_d = w;
            rem_n  = rem_n + 7'(w);
            ts_d   = ts_q + 7'(w);
          end
          hsync_d = 1'b1;
          if (vmode_d != usnt_pkg::VsOff || hold_d) begin
            row_d  = '0;
            hold_d = 1'b0;
          end else begin
            row_d = row_q + 3'd1;
          end
          stage_d = usnt_pkg::HsInSync;
        end
        // End horizontal sync
        if (stage_d == usnt_pkg::HsInSync && phase_d >= usnt_pkg::HsEnd) begin
          if (vmode_d == usnt_pkg::VsEndNext) begin
            vmode_d = usnt_pkg::VsOff;
          end
          hsync_d = 1'b0;
          stage_d = usnt_pkg::HsIdle;
        end
        sync_d = !(vmode_d != usnt_pkg::VsOff || hsync_d);
        rem_d  = rem_n;
        if (rem_n == '0) begin
          state_d = StFrame;
        end
      end

      StFrame: begin
        // Accumulate frame states and deliver once the output register is free
        sum = {1'b0, total_q} + {11'd0, ts_q};
        if (sum >= {1'b0, flen_q}) begin
          sum  = sum - {1'b0, flen_q};
          tick = 1'b1;
        end
        if (!out_valid_q || !out_stall_i) begin
          total_d            = sum[16:0];
          out_d.nmi_request  = nreq_q;
          out_d.wait_states  = wait_q;
          out_d.row_count    = row_q;
          out_d.sync_level   = sync_q;
          out_d.vsync_active = (vmode_q != usnt_pkg::VsOff);
          out_d.frame_tick   = tick;
          out_valid_d        = 1'b1;
          state_d            = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  // Control and timing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= '0;
      stage_q     <= usnt_pkg::HsIdle;
      nmi_en_q    <= 1'b0;
      vmode_q     <= usnt_pkg::VsOff;
      hsync_q     <= 1'b0;
      row_q       <= '0;
      hold_q      <= 1'b0;
      total_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      stage_q     <= stage_d;
      nmi_en_q    <= nmi_en_d;
      vmode_q     <= vmode_d;
      hsync_q     <= hsync_d;
      row_q       <= row_d;
      hold_q      <= hold_d;
      total_q     <= total_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ts_q    <= ts_d;
    short_q <= short_d;
    nreq_q  <= nreq_d;
    wait_q  <= wait_d;
    sync_q  <= sync_d;
    out_q   <= out_d;
  end

`include "ula_sync_nmi_timing_defines.svh"

  `USNT_ASSERT_NOW(a_phase_range, 1'b1, phase_q >= usnt_pkg::AckPhase && phase_q <= 9'sd214, "line phase left its range")
  `USNT_ASSERT_NOW(a_stage_legal, 1'b1, stage_q != 2'd3, "hsync stage reached an unused code")
  `USNT_ASSERT_NEXT(a_load_from_frame, !out_valid_q || !out_stall_i, !out_valid_q || $past(state_q) == StFrame, "result loaded outside the frame step")
  `USNT_ASSERT_NOW(a_wait_needs_nmi, out_valid_q && out_q.wait_states != '0, out_q.nmi_request, "wait states without an NMI request")
  `USNT_ASSERT_NOW(a_rem_bounded, state_q == StChunk, rem_q <= ts_q, "remaining states exceed step states")

endmodule

`default_nettype wire

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import usnt_pkg::*;

  // Line timing, kept apart from the package so that the prediction does not rely on its timing values
  localparam int LinePeriod    = 207;
  localparam int SyncStart     = 16;
  localparam int SyncStop      = 32;
  localparam int HoldLatePhase = 178;
  localparam int WaitFixed     = 14;
  localparam int WaitCeiling   = 31;
  localparam int ChunkStates   = 8;
  localparam int AckLinePos    = -2;

  localparam int SettleCycles  = 24;
  localparam int CycleLimit    = 400000;
  localparam int RandomPhases  = 6;
  localparam int StepsPerPhase = 80;
  localparam int ProbeCount    = 25;
  localparam int ReportCap     = 60;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  step_t          in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  timing_t        out_data_o;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [2:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  ula_sync_nmi_timing dut (.*);

  // Directed probe: mode, step, and a typed-in result where it is obvious
  typedef struct packed {
    logic    early;
    step_t   stim;
    logic    pinned;
    timing_t want;
  } probe_row_t;

  localparam timing_t Quiet     = '{1'b0, 5'd0, 3'd0, 1'b1, 1'b0, 1'b0};
  localparam timing_t VsyncOnly = '{1'b0, 5'd0, 3'd0, 1'b0, 1'b1, 1'b0};

  probe_row_t probe_table [ProbeCount] = '{
    '{1'b0, '{6'd0,  EvNone,     1'b0}, 1'b1, Quiet},
    '{1'b0, '{6'd63, EvNone,     1'b0}, 1'b1, Quiet},
    '{1'b0, '{6'd0,  EvInEven,   1'b0}, 1'b1, VsyncOnly},
    '{1'b0, '{6'd8,  EvNone,     1'b1}, 1'b0, Quiet},
    '{1'b0, '{6'd16, EvOutOther, 1'b0}, 1'b0, Quiet},
    '{1'b0, '{6'd40, EvOutFd,    1'b0}, 1'b0, Quiet},
    '{1'b0, '{6'd0,  3'd5,       1'b0}, 1'b0, Quiet},
    '{1'b0, '{6'd0,  3'd6,       1'b0}, 1'b0, Quiet},
    '{1'b0, '{6'd0,  3'd7,       1'b0}, 1'b0, Quiet},
    '{1'b0, '{6'd63, EvOutFe,    1'b0}, 1'b0, Quiet},
    '{1'b0, '{6'd63, EvNone,     1'b0}, 1'b0, Quiet},
    '{1'b0, '{6'd63, EvNone,     1'b0}, 1'b0, Quiet},
    '{1'b0, '{6'd63, EvNone,     1'b0}, 1'b0, Quiet},
    '{1'b0, '{6'd4,  EvNone,     1'b1}, 1'b0, Quiet},
    '{1'b0, '{6'd4,  EvNone,     1'b0}, 1'b0, Quiet},
    '{1'b0, '{6'd4,  EvNone,     1'b0}, 1'b0, Quiet},
    '{1'b0, '{6'd4,  EvNone,     1'b0}, 1'b0, Quiet},
    '{1'b0, '{6'd4,  EvNone,     1'b0}, 1'b0, Quiet},
    '{1'b1, '{6'd0,  EvNone,     1'b1}, 1'b0, Quiet},
    '{1'b1, '{6'd20, EvNone,     1'b0}, 1'b0, Quiet},
    '{1'b1, '{6'd60, EvNone,     1'b0}, 1'b0, Quiet},
    '{1'b1, '{6'd4,  EvOutOther, 1'b0}, 1'b0, Quiet},
    '{1'b0, '{6'd4,  EvOutFd,    1'b0}, 1'b0, Quiet},
    '{1'b1, '{6'd10, EvInEven,   1'b0}, 1'b0, Quiet},
    '{1'b1, '{6'd63, EvOutFe,    1'b0}, 1'b0, Quiet}
  };

  // Mirror of the timing state and registers
  int          line_pos;
  logic [1:0]  sync_stage;
  logic        nmi_on;
  logic [1:0]  vs_mode;
  logic        hsync_high;
  logic [2:0]  row_ctr;
  logic        row_hold_f;
  logic [16:0] state_acc;
  logic        early_mode;
  logic [16:0] frame_len;

  timing_t pending_timing_q [$];
  bit      steady;
  int      errors;
  int      cycles;
  int      steps_sent;
  int      results_seen;
  int      nmi_seen;
  int      clamp_hits;
  int      ticks_seen;
  int      settings_used;

  // Port write side effect on vertical sync
  function automatic void apply_port_write();
    if (vs_mode != VsOff) begin
      if (early_mode) begin
        vs_mode = VsEndNext;
      end else begin
        vs_mode = VsOff;
        if (line_pos < SyncStart || line_pos >= HoldLatePhase) row_hold_f = 1'b1;
      end
    end
  endfunction

  // Advance the line timing by one CPU step and form its result
  function automatic timing_t advance_timing(step_t s);
    timing_t    r;
    int         states;
    int         left;
    int         inc;
    int         w;
    int         sum;
    logic [2:0] ev;
    r = '0;
    states = int'(s.step_states);
    ev = s.io_event;
    if (s.int_ack) begin
      line_pos = AckLinePos;
      sync_stage = HsArmed;
    end
    if (early_mode && (ev == EvOutFd || ev == EvOutFe)) ev = EvOutOther;
    case (ev)
      EvInEven: begin
        if (!nmi_on && vs_mode == VsOff) vs_mode = VsOn;
      end
      EvOutFd: begin
        nmi_on = 1'b0;
        apply_port_write();
      end
      EvOutFe: begin
        nmi_on = 1'b1;
        apply_port_write();
      end
      EvOutOther: begin
        apply_port_write();
        if (early_mode) sync_stage = HsArmed;
      end
      default: ;
    endcase
    // Walk the step in chunks; wait states lengthen the walk
    left = states;
    do begin
      inc = (left > ChunkStates) ? ChunkStates : left;
      left -= inc;
      line_pos += inc;
      if (line_pos >= LinePeriod) begin
        line_pos -= LinePeriod;
        if (!early_mode) sync_stage = HsArmed;
      end
      if (sync_stage == HsArmed && line_pos >= SyncStart) begin
        if (nmi_on) begin
          w = WaitFixed;
          if (states == 4) w = WaitFixed + 3 - left - (line_pos - SyncStart);
          if (w < 0) begin
            w = 0;
            clamp_hits++;
          end
          if (w > WaitCeiling) w = WaitCeiling;
          r.nmi_request = 1'b1;
          r.wait_states = 5'(w);
          left += w;
          states += w;
        end
        hsync_high = 1'b1;
        if (vs_mode != VsOff || row_hold_f) begin
          row_ctr = 3'd0;
          row_hold_f = 1'b0;
        end else begin
          row_ctr = row_ctr + 3'd1;
        end
        sync_stage = HsInSync;
      end
      if (sync_stage == HsInSync && line_pos >= SyncStop) begin
        if (vs_mode == VsEndNext) vs_mode = VsOff;
        hsync_high = 1'b0;
        sync_stage = HsIdle;
      end
    end while (left != 0);
    r.sync_level = !(vs_mode != VsOff || hsync_high);
    r.vsync_active = (vs_mode != VsOff);
    r.row_count = row_ctr;
    // Frame accumulator: one compare and reduce per step
    sum = int'(state_acc) + states;
    if (sum >= int'(frame_len)) begin
      sum -= int'(frame_len);
      r.frame_tick = 1'b1;
    end
    state_acc = 17'(sum);
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic step_t random_step();
    step_t s;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 15)      s.step_states = 6'd4;
    else if (r < 20) s.step_states = 6'd63;
    else if (r < 23) s.step_states = 6'd0;
    else             s.step_states = 6'($urandom_range(0, 63));
    r = $urandom_range(0, 99);
    if (r < 45)      s.io_event = EvNone;
    else if (r < 57) s.io_event = EvInEven;
    else if (r < 67) s.io_event = EvOutFd;
    else if (r < 79) s.io_event = EvOutFe;
    else if (r < 93) s.io_event = EvOutOther;
    else             s.io_event = 3'($urandom_range(5, 7));
    s.int_ack = ($urandom_range(0, 19) == 0);
    return s;
  endfunction

  // Offer one step, hold it until the transfer, then predict its result
  task automatic send_step(step_t s, logic pinned, timing_t pinned_want);
    timing_t pred;
    int      gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    pred = advance_timing(s);
    if (pred.nmi_request) nmi_seen++;
    if (pred.frame_tick) ticks_seen++;
    pending_timing_q.push_back(pinned ? pinned_want : pred);
    steps_sent++;
    @(negedge clk_i);
  endtask

  // One APB transfer: setup, access, then return to idle
  task automatic apb_access(logic wr, logic idx, logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_reg(logic idx, logic [31:0] want);
    logic [31:0] got;
    apb_access(1'b0, idx, 32'd0, got);
    if (got !== want) begin
      $display("%0t ns: register %0d read, expected %0h, got %0h", $time, idx, want, got);
      errors++;
    end
  endtask

  // Drain, then write both registers and read them back
  task automatic program_timing(logic mode, logic [16:0] len);
    logic [31:0] unused;
    in_valid_i <= 1'b0;
    while (pending_timing_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    apb_access(1'b1, RegEarlyMode, {31'd0, mode}, unused);
    apb_access(1'b1, RegFrameLength, {15'd0, len}, unused);
    early_mode = mode;
    frame_len = len;
    check_reg(RegEarlyMode, {31'd0, mode});
    check_reg(RegFrameLength, {15'd0, len});
    settings_used++;
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      if (errors < ReportCap)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_timing(timing_t got);
    timing_t want;
    if (pending_timing_q.size() == 0) begin
      $display("%0t ns: result with none expected, got %p", $time, got);
      errors++;
    end else begin
      want = pending_timing_q.pop_front();
      compare_field("nmi_request", want.nmi_request, got.nmi_request);
      compare_field("wait_states", want.wait_states, got.wait_states);
      compare_field("row_count", want.row_count, got.row_count);
      compare_field("sync_level", want.sync_level, got.sync_level);
      compare_field("vsync_active", want.vsync_active, got.vsync_active);
      compare_field("frame_tick", want.frame_tick, got.frame_tick);
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      check_timing(out_data_o);
    end
  end

  // Result side back-pressure
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      n = pick_gap();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    logic        phase_mode [RandomPhases];
    logic [16:0] phase_len [RandomPhases];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 1'b0;
    line_pos = 0;
    sync_stage = HsIdle;
    nmi_on = 1'b0;
    vs_mode = VsOff;
    hsync_high = 1'b0;
    row_ctr = 3'd0;
    row_hold_f = 1'b0;
    state_acc = '0;
    early_mode = 1'b0;
    frame_len = FrameLenReset;

    // Settings for the random part, extremes among them
    phase_mode = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    phase_len = '{17'd65000, 17'd1, 17'd131071, 17'd131071,
                  17'($urandom_range(1, 400)), 17'($urandom_range(2000, 20000))};

    // Hold reset, then release it on a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    check_reg(RegEarlyMode, 32'd0);
    check_reg(RegFrameLength, {15'd0, FrameLenReset});

    // Directed probe
    for (int i = 0; i < ProbeCount; i++) begin
      if (probe_table[i].early != early_mode)
        program_timing(probe_table[i].early, frame_len);
      send_step(probe_table[i].stim, probe_table[i].pinned, probe_table[i].want);
    end

    // Random phases, one per register setting
    for (int p = 0; p < RandomPhases; p++) begin
      program_timing(phase_mode[p], phase_len[p]);
      for (int k = 0; k < StepsPerPhase; k++) begin
        if (k % 40 == 0) steady = ($urandom_range(0, 4) == 0);
        send_step(random_step(), 1'b0, Quiet);
      end
    end

    // Drop valid and let the last results drain
    in_valid_i <= 1'b0;
    steady = 1'b0;
    while (pending_timing_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Covered %0d steps over %0d register settings; %0d results checked.",
             steps_sent, settings_used, results_seen);
    $display("Seen: %0d NMI requests, %0d clamped wait counts, %0d frame ticks.",
             nmi_seen, clamp_hits, ticks_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/usnt_pkg.sv
rtl/core/ula_sync_nmi_timing.sv
tb/testbench.sv
